@@ src/polst_pkg.sv @@
package polst_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned IdW      = 32;
  localparam int unsigned LabelW   = 64;
  localparam int unsigned PosW     = 8;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 3;
  // wide enough for any position and any count up to 256 entries, plus one
  localparam int unsigned CmpW     = 10;

  localparam logic [CmdW-1:0] CmdInsert  = 2'd0;
  localparam logic [CmdW-1:0] CmdDelete  = 2'd1;
  localparam logic [CmdW-1:0] CmdListFwd = 2'd2;
  localparam logic [CmdW-1:0] CmdListBwd = 2'd3;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StBadPos   = 3'd1;
  localparam logic [StatusW-1:0] StFull     = 3'd2;
  localparam logic [StatusW-1:0] StEmpty    = 3'd3;
  localparam logic [StatusW-1:0] StNotFound = 3'd4;

  typedef struct packed {
    logic signed [IdW-1:0] id;
    logic [LabelW-1:0]     label;
  } entry_t;

  typedef enum logic [2:0] {
    CellHold,
    CellIns,
    CellDel,
    CellRotFwd,
    CellRotBwd
  } cell_op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e              op;
    logic signed [IdW-1:0] key_id;
    entry_t                new_entry;
  } cell_ctrl_t;

endpackage

@@ src/polst_cell.sv @@
module polst_cell #(
  parameter int unsigned Depth = polst_pkg::DefDepth,
  parameter int unsigned Idx   = 0,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                          clk_i,
  input  polst_pkg::cell_ctrl_t         ctrl_i,
  input  logic [polst_pkg::PosW-1:0]    pos_i,
  input  logic [CntW-1:0]               cnt_i,
  input  polst_pkg::entry_t             left_i,
  input  polst_pkg::entry_t             right_i,
  input  polst_pkg::entry_t             head_i,
  input  logic                          hit_i,
  output logic                          hit_o,
  output logic                          tail_o,
  output polst_pkg::entry_t             data_o
);

  localparam logic [polst_pkg::CmpW-1:0] Num = polst_pkg::CmpW'(Idx + 1);

  polst_pkg::entry_t data_q, data_d;
  logic [polst_pkg::CmpW-1:0] pos_w, cnt_w;
  logic valid, hit, new_here, shift_here;

  assign pos_w      = polst_pkg::CmpW'(pos_i);
  assign cnt_w      = polst_pkg::CmpW'(cnt_i);
  assign valid      = (Num <= cnt_w);
  assign tail_o     = (Num == cnt_w);
  assign hit        = valid && (data_q.id == ctrl_i.key_id);
  // hit_i means an earlier cell already matched
  assign hit_o      = hit_i | hit;
  assign new_here   = (pos_w == Num);
  assign shift_here = (pos_w < Num);
  assign data_o     = data_q;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      polst_pkg::CellIns: begin
        if (new_here) begin
          data_d = ctrl_i.new_entry;
        end else if (shift_here) begin
          data_d = left_i;
        end
      end
      polst_pkg::CellDel: begin
        if (hit_o) begin
          data_d = right_i;
        end
      end
      // front entry wraps around to the tail
      polst_pkg::CellRotFwd: data_d = tail_o ? head_i : right_i;
      // tail entry comes in at the front through left_i of cell zero
      polst_pkg::CellRotBwd: data_d = left_i;
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

@@ src/positional_ordered_list_core.sv @@
// Ordered list of up to Depth entries held in a chain of cells, one entry per
// cell, front of the list in cell zero. Insert and delete shift the whole
// chain at once, so with the result side ready they take one word per
// cycle. A listing rotates the chain by one cell per cycle while the result
// side is ready and streams one word per entry; no new word is accepted
// until the last result has been registered. Every command answers with at
// least one result word, the final one flagged by last_o.
module positional_ordered_list_core #(
  parameter int unsigned Depth = polst_pkg::DefDepth,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [polst_pkg::CmdW-1:0]           command_i,
  input  logic [polst_pkg::PosW-1:0]           position_i,
  input  logic signed [polst_pkg::IdW-1:0]     key_id_i,
  input  logic [polst_pkg::LabelW-1:0]         label_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [polst_pkg::StatusW-1:0]        status_o,
  output logic signed [polst_pkg::IdW-1:0]     entry_id_o,
  output logic [polst_pkg::LabelW-1:0]         entry_label_o,
  output logic                                 last_o
);

  typedef enum logic {StIdle, StList} state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, rem_q, rem_d;
  logic dir_bwd_q, dir_bwd_d;
  logic out_valid_q, out_valid_d, last_q, last_d;
  logic [polst_pkg::StatusW-1:0] status_q, status_d;
  polst_pkg::entry_t out_q, out_d;

  polst_pkg::cell_ctrl_t ctrl;
  polst_pkg::cell_op_e cell_op;
  polst_pkg::entry_t cell_data [Depth];
  polst_pkg::entry_t tail_data;
  logic [Depth-1:0] tail_flag;
  logic [Depth:0] hit_chain;
  logic ld, accept, bad_pos, full;
  logic [polst_pkg::CmpW-1:0] pos_w, cnt_w;

  assign ld         = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && ld;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_w      = polst_pkg::CmpW'(position_i);
  assign cnt_w      = polst_pkg::CmpW'(cnt_q);
  assign bad_pos    = (position_i == '0) || (pos_w > cnt_w + polst_pkg::CmpW'(1));
  assign full       = (cnt_w == polst_pkg::CmpW'(Depth));
  assign hit_chain[0] = 1'b0;

  assign ctrl.op              = cell_op;
  assign ctrl.key_id          = key_id_i;
  assign ctrl.new_entry.id    = key_id_i;
  assign ctrl.new_entry.label = label_i;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    polst_cell #(
      .Depth (Depth),
      .Idx   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (position_i),
      .cnt_i   (cnt_q),
      .left_i  ((g == 0) ? tail_data : cell_data[(g == 0) ? 0 : g - 1]),
      .right_i ((g == Depth - 1) ? cell_data[0] : cell_data[(g == Depth - 1) ? 0 : g + 1]),
      .head_i  (cell_data[0]),
      .hit_i   (hit_chain[g]),
      .hit_o   (hit_chain[g+1]),
      .tail_o  (tail_flag[g]),
      .data_o  (cell_data[g])
    );
  end

  // one-hot pick of the tail cell
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < Depth; i++) begin
      if (tail_flag[i]) begin
        tail_data = tail_data | cell_data[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dir_bwd_d   = dir_bwd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    out_d       = out_q;
    last_d      = last_q;
    cell_op     = polst_pkg::CellHold;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          last_d      = 1'b1;
          status_d    = polst_pkg::StOk;
          case (command_i)
            polst_pkg::CmdInsert: begin
              if (bad_pos) begin
                status_d = polst_pkg::StBadPos;
              end else if (full) begin
                status_d = polst_pkg::StFull;
              end else begin
                cell_op = polst_pkg::CellIns;
                cnt_d   = cnt_q + CntW'(1);
              end
            end
            polst_pkg::CmdDelete: begin
              if (cnt_q == '0) begin
                status_d = polst_pkg::StEmpty;
              end else if (!hit_chain[Depth]) begin
                status_d = polst_pkg::StNotFound;
              end else begin
                cell_op = polst_pkg::CellDel;
                cnt_d   = cnt_q - CntW'(1);
              end
            end
            default: begin
              if (cnt_q == '0) begin
                status_d = polst_pkg::StEmpty;
              end else begin
                // entries come out of the list state
                out_valid_d = 1'b0;
                state_d     = StList;
                rem_d       = cnt_q;
                dir_bwd_d   = (command_i == polst_pkg::CmdListBwd);
              end
            end
          endcase
        end
      end
      StList: begin
        if (ld) begin
          out_valid_d = 1'b1;
          status_d    = polst_pkg::StOk;
          out_d       = dir_bwd_q ? tail_data : cell_data[0];
          last_d      = (rem_q == CntW'(1));
          cell_op     = dir_bwd_q ? polst_pkg::CellRotBwd : polst_pkg::CellRotFwd;
          rem_d       = rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rem_q       <= '0;
      dir_bwd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      dir_bwd_q   <= dir_bwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    out_q    <= out_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_id_o    = out_q.id;
  assign entry_label_o = out_q.label;
  assign last_o        = last_q;

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;

  localparam int ListDepth = polst_pkg::DefDepth;
  localparam int RandomWords = 500;

  typedef struct packed {
    logic [polst_pkg::StatusW-1:0]    status;
    logic signed [polst_pkg::IdW-1:0] id;
    logic [polst_pkg::LabelW-1:0]     label;
    logic                             last;
  } result_t;

  // one row of the directed plan; typed rows carry their status-only answer
  typedef struct packed {
    logic [polst_pkg::CmdW-1:0]       cmd;
    logic [polst_pkg::PosW-1:0]       pos;
    logic signed [polst_pkg::IdW-1:0] key;
    logic [polst_pkg::LabelW-1:0]     lab;
    logic                             typed;
    logic [polst_pkg::StatusW-1:0]    status;
  } plan_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic [polst_pkg::CmdW-1:0]       command_i = polst_pkg::CmdListFwd;
  logic [polst_pkg::PosW-1:0]       position_i = '0;
  logic signed [polst_pkg::IdW-1:0] key_id_i = '0;
  logic [polst_pkg::LabelW-1:0]     label_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic [polst_pkg::StatusW-1:0]    status_o;
  logic signed [polst_pkg::IdW-1:0] entry_id_o;
  logic [polst_pkg::LabelW-1:0]     entry_label_o;
  logic                             last_o;

  // shadow copy of the list, front in slot zero
  logic signed [polst_pkg::IdW-1:0] list_ids [ListDepth];
  logic [polst_pkg::LabelW-1:0]     list_labels [ListDepth];
  int                               list_len = 0;

  result_t               answer_q [$];
  result_t               pending_q [$];
  int                    err_cnt = 0;
  bit                    growing = 1'b1;

  positional_ordered_list_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .position_i   (position_i),
    .key_id_i     (key_id_i),
    .label_i      (label_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .entry_id_o   (entry_id_o),
    .entry_label_o(entry_label_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic result_t status_word(input logic [polst_pkg::StatusW-1:0] st);
    result_t r;
    r.status = st;
    r.id     = '0;
    r.label  = '0;
    r.last   = 1'b1;
    return r;
  endfunction

  // applies one command to the shadow list and leaves its answers in answer_q
  function automatic void apply_command(input logic [polst_pkg::CmdW-1:0] cmd,
                                        input logic [polst_pkg::PosW-1:0] pos,
                                        input logic signed [polst_pkg::IdW-1:0] key,
                                        input logic [polst_pkg::LabelW-1:0] lab);
    int      i;
    int      hit;
    int      slot;
    int      p = int'(pos);
    result_t r;
    answer_q.delete();
    case (cmd)
      polst_pkg::CmdInsert: begin
        if (p == 0 || p > list_len + 1) begin
          answer_q.push_back(status_word(polst_pkg::StBadPos));
        end else if (list_len >= ListDepth) begin
          answer_q.push_back(status_word(polst_pkg::StFull));
        end else begin
          for (i = list_len; i > p - 1; i--) begin
            list_ids[i]    = list_ids[i-1];
            list_labels[i] = list_labels[i-1];
          end
          list_ids[p-1]    = key;
          list_labels[p-1] = lab;
          list_len++;
          answer_q.push_back(status_word(polst_pkg::StOk));
        end
      end
      polst_pkg::CmdDelete: begin
        hit = -1;
        for (i = 0; i < list_len; i++) begin
          if (hit < 0 && list_ids[i] == key) hit = i;
        end
        if (list_len == 0) begin
          answer_q.push_back(status_word(polst_pkg::StEmpty));
        end else if (hit < 0) begin
          answer_q.push_back(status_word(polst_pkg::StNotFound));
        end else begin
          for (i = hit; i + 1 < list_len; i++) begin
            list_ids[i]    = list_ids[i+1];
            list_labels[i] = list_labels[i+1];
          end
          list_len--;
          answer_q.push_back(status_word(polst_pkg::StOk));
        end
      end
      default: begin
        if (list_len == 0) begin
          answer_q.push_back(status_word(polst_pkg::StEmpty));
        end else begin
          for (i = 0; i < list_len; i++) begin
            slot     = (cmd == polst_pkg::CmdListFwd) ? i : list_len - 1 - i;
            r.status = polst_pkg::StOk;
            r.id     = list_ids[slot];
            r.label  = list_labels[slot];
            r.last   = (i == list_len - 1);
            answer_q.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // idle length for one word; runs of zero come from the calm flag
  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic signed [polst_pkg::IdW-1:0] draw_key();
    // small pool so duplicates show up often
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 15) - 8;
  endfunction

  bit send_calm = 1'b0;

  // called at a rising edge; returns at the edge that accepts the word
  task automatic send_word(input logic [polst_pkg::CmdW-1:0] cmd,
                           input logic [polst_pkg::PosW-1:0] pos,
                           input logic signed [polst_pkg::IdW-1:0] key,
                           input logic [polst_pkg::LabelW-1:0] lab,
                           input logic typed,
                           input logic [polst_pkg::StatusW-1:0] st);
    int unsigned gap;
    gap = draw_gap(send_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i  <= cmd;
    position_i <= pos;
    key_id_i   <= key;
    label_i    <= lab;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_command(cmd, pos, key, lab);
    if (typed) pending_q.push_back(status_word(st));
    else foreach (answer_q[k]) pending_q.push_back(answer_q[k]);
  endtask

  task automatic send_row(input plan_row_t row);
    send_word(row.cmd, row.pos, row.key, row.lab, row.typed, row.status);
  endtask

  task automatic send_random();
    logic [polst_pkg::CmdW-1:0]       cmd;
    logic [polst_pkg::PosW-1:0]       pos;
    logic signed [polst_pkg::IdW-1:0] key;
    logic [polst_pkg::LabelW-1:0]     lab;
    int unsigned                      pick;
    int unsigned                      ins_pct;
    int unsigned                      del_pct;
    if (list_len == ListDepth) growing = 1'b0;
    else if (list_len == 0) growing = 1'b1;
    else if ($urandom_range(0, 49) == 0) growing = !growing;
    ins_pct = growing ? 60 : 15;
    del_pct = growing ? 10 : 50;
    pick = $urandom_range(0, 99);
    cmd  = polst_pkg::CmdInsert;
    pos  = polst_pkg::PosW'($urandom_range(1, list_len + 1));
    key  = draw_key();
    lab  = {$urandom, $urandom};
    if (pick < ins_pct) begin
      cmd = polst_pkg::CmdInsert;
    end else if (pick < ins_pct + del_pct) begin
      cmd = polst_pkg::CmdDelete;
      if (list_len != 0) key = list_ids[$urandom_range(0, list_len - 1)];
    end else if (pick < ins_pct + del_pct + 8) begin
      cmd = polst_pkg::CmdDelete;
    end else if (pick < ins_pct + del_pct + 14) begin
      pos = polst_pkg::PosW'($urandom_range(0, 255));
    end else begin
      cmd = $urandom_range(0, 1) ? polst_pkg::CmdListFwd : polst_pkg::CmdListBwd;
    end
    send_word(cmd, pos, key, lab, 1'b0, polst_pkg::StOk);
  endtask

  task automatic check_word();
    result_t want;
    if (pending_q.size() == 0) begin
      $error("unexpected word: status %0d entry_id %0d entry_label %h last %0b",
             status_o, entry_id_o, entry_label_o, last_o);
      err_cnt++;
    end else begin
      want = pending_q.pop_front();
      if (status_o !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status_o);
        err_cnt++;
      end
      if (entry_id_o !== want.id) begin
        $error("entry_id: expected %0d, got %0d", want.id, entry_id_o);
        err_cnt++;
      end
      if (entry_label_o !== want.label) begin
        $error("entry_label: expected %h, got %h", want.label, entry_label_o);
        err_cnt++;
      end
      if (last_o !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last_o);
        err_cnt++;
      end
    end
  endtask

  initial begin : result_side
    int unsigned stall;
    bit          calm;
    calm = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap(calm);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_word();
    end
  end

  initial begin : stim
    plan_row_t plan [13];
    plan_row_t full_plan [3];
    plan = '{
      '{polst_pkg::CmdListFwd, 8'd0, 32'sd0, 64'd0, 1'b1, polst_pkg::StEmpty},
      '{polst_pkg::CmdDelete, 8'd1, 32'sd5, 64'd0, 1'b1, polst_pkg::StEmpty},
      '{polst_pkg::CmdInsert, 8'd0, 32'sd1, 64'd1, 1'b1, polst_pkg::StBadPos},
      '{polst_pkg::CmdInsert, 8'd255, 32'sd2, 64'd2, 1'b1, polst_pkg::StBadPos},
      '{polst_pkg::CmdInsert, 8'd1, 32'sh8000_0000, 64'hffff_ffff_ffff_ffff, 1'b1,
        polst_pkg::StOk},
      '{polst_pkg::CmdInsert, 8'd2, 32'sh7fff_ffff, 64'd0, 1'b1, polst_pkg::StOk},
      '{polst_pkg::CmdInsert, 8'd2, -32'sd1, 64'h0123_4567_89ab_cdef, 1'b1,
        polst_pkg::StOk},
      // duplicate id at the front
      '{polst_pkg::CmdInsert, 8'd1, 32'sh7fff_ffff, 64'h4e41_4d45_0000_0000, 1'b1,
        polst_pkg::StOk},
      '{polst_pkg::CmdListFwd, 8'd0, 32'sd0, 64'd0, 1'b0, polst_pkg::StOk},
      '{polst_pkg::CmdListBwd, 8'd0, 32'sd0, 64'd0, 1'b0, polst_pkg::StOk},
      '{polst_pkg::CmdDelete, 8'd0, 32'sh7fff_ffff, 64'd0, 1'b1, polst_pkg::StOk},
      '{polst_pkg::CmdDelete, 8'd0, 32'sd12345, 64'd0, 1'b1, polst_pkg::StNotFound},
      '{polst_pkg::CmdInsert, 8'd5, 32'sd3, 64'd3, 1'b1, polst_pkg::StBadPos}
    };
    full_plan = '{
      '{polst_pkg::CmdInsert, 8'd17, 32'sd9, 64'd9, 1'b1, polst_pkg::StFull},
      '{polst_pkg::CmdInsert, 8'd18, 32'sd9, 64'd9, 1'b1, polst_pkg::StBadPos},
      '{polst_pkg::CmdListBwd, 8'd0, 32'sd0, 64'd0, 1'b0, polst_pkg::StOk}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) send_row(plan[r]);
    while (list_len < ListDepth) begin
      send_word(polst_pkg::CmdInsert, polst_pkg::PosW'($urandom_range(1, list_len + 1)),
                draw_key(), {$urandom, $urandom}, 1'b0, polst_pkg::StOk);
    end
    foreach (full_plan[r]) send_row(full_plan[r]);

    for (int n = 0; n < RandomWords; n++) begin
      if (n == RandomWords / 2) begin
        // hold off until the list has answered everything so far
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      send_random();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (2 * ListDepth + 8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
